### rtl/ita_pkg.sv
`timescale 1ns / 1ps

package ita_pkg;

   // Widths of the number and of the decimal digit register.
   localparam int VALUE_BITS  = 64;
   localparam int MAX_DIGITS  = 20;
   localparam int DIGIT_BITS  = 4 * MAX_DIGITS;
   localparam int COUNT_BITS  = 5;
   localparam int WIDTH_BITS  = 7;
   localparam int CHAR_BITS   = 7;
   localparam int STEP_BITS   = 6;
   localparam int HEX_DIGITS  = VALUE_BITS / 4;

   // ASCII codes that the formatter emits.
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 7'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;

   // Maps one digit of base ten or sixteen to its ASCII character.
   function automatic logic [CHAR_BITS-1:0] digit_char(logic [3:0] digit, logic upper);
      logic [CHAR_BITS-1:0] result;
      if (digit < 4'd10) begin
         result = CHAR_ZERO + {3'b000, digit};
      end else begin
         result = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {3'b000, digit} - 7'd10;
      end
      return result;
   endfunction

endpackage

### rtl/ita_if.sv
`timescale 1ns / 1ps

// Channel that carries one number and its format options per word.
interface ita_req_if import ita_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [VALUE_BITS-1:0]        value;
   logic                         is_signed;
   logic                         use_hex;
   logic                         upper_case;
   logic                         zero_pad;
   logic signed [WIDTH_BITS-1:0] field_width;

   modport source (output valid, value, is_signed, use_hex, upper_case, zero_pad,
                   field_width, input ready);
   modport sink (input valid, value, is_signed, use_hex, upper_case, zero_pad,
                 field_width, output ready);
endinterface

// Channel that carries one ASCII character per word.
interface ita_rsp_if import ita_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] character;
   logic                 last;

   modport source (output valid, character, last, input ready);
   modport sink (input valid, character, last, output ready);
endinterface

### rtl/ita_bcd_conv.sv
`timescale 1ns / 1ps

// Shift-and-add-three binary to BCD converter: one bit of the number per cycle.
module ita_bcd_conv import ita_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] bin,
   output logic                  done,
   output logic [DIGIT_BITS-1:0] bcd
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [VALUE_BITS-1:0] bin_ff;
   logic [DIGIT_BITS-1:0] bcd_ff;
   logic [DIGIT_BITS-1:0] adjust;

   // Every BCD digit of five or more gets three added before the shift.
   always_comb begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            adjust[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            adjust[4*k +: 4] = bcd_ff[4*k +: 4];
         end
      end
   end

   // Control: the conversion runs for one step per bit of the number.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_BITS'(VALUE_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: the adjusted digits and the number shift left as one word.
   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff <= bin;
         bcd_ff <= '0;
      end else if (busy_ff) begin
         {bcd_ff, bin_ff} <= {adjust[DIGIT_BITS-2:0], bin_ff, 1'b0};
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

### rtl/integer_to_ascii_formatter_top.sv
`timescale 1ns / 1ps

// Integer to ASCII formatter.
// The req channel takes one word per number: a 64-bit value with signed, hex,
// upper-case and zero-pad flags and a signed field width. The rsp channel then
// gives the text one ASCII character per word, with last set on the final one.
// A negative signed number starts with a minus sign, which takes one place of
// the width; signed numbers are always printed in decimal.
// Decimal digits come from a shift-and-add-three converter that handles one
// bit of the number per cycle; a hex number skips the converter. A scan then
// drops leading zero digits, one digit per cycle, but keeps at least one. A
// setup state follows, and then one character leaves per cycle while the
// receiver takes them.
// req ready is high only while no number is in work, so one number at a time.
// When the receiver stalls, the output register holds its character and the
// emission waits; no character is lost.
// Reset is synchronous and returns the block to idle with no output pending.
module integer_to_ascii_formatter_top import ita_pkg::*; (
   input logic         clock,
   input logic         reset,
   ita_req_if.sink     req_chan,
   ita_rsp_if.source   rsp_chan
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]            state_ff;
   logic                  neg_ff;
   logic                  upper_ff;
   logic                  zero_pad_ff;
   logic signed [7:0]     width_ff;
   logic [DIGIT_BITS-1:0] digit_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] dleft_ff;
   logic [5:0]            zcnt_ff;
   logic [6:0]            rem_ff;
   logic                  sign_pend_ff;
   logic                  rsp_valid_ff;
   logic [CHAR_BITS-1:0]  char_ff;
   logic                  last_ff;

   logic                  accept;
   logic                  negative;
   logic [VALUE_BITS-1:0] magnitude;
   logic                  conv_start;
   logic                  conv_done;
   logic [DIGIT_BITS-1:0] conv_bcd;
   logic                  emit;
   logic [3:0]            top_digit;
   logic signed [7:0]     count_s;
   logic signed [7:0]     pad_diff;
   logic [CHAR_BITS-1:0]  char_in;

   assign accept     = req_chan.valid && req_chan.ready;
   assign negative   = req_chan.is_signed && req_chan.value[VALUE_BITS-1];
   assign magnitude  = negative ? (~req_chan.value + 1'b1) : req_chan.value;
   assign conv_start = accept && !(req_chan.use_hex && !req_chan.is_signed);
   assign req_chan.ready = (state_ff == ST_IDLE);

   ita_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .bin   (magnitude),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   assign top_digit = digit_ff[DIGIT_BITS-1 -: 4];
   assign count_s   = $signed({3'b000, count_ff});
   assign pad_diff  = width_ff - count_s;
   assign emit      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   // Character choice: sign first, then zero padding, digits and spaces.
   always_comb begin
      if (sign_pend_ff) begin
         char_in = CHAR_MINUS;
      end else if (zcnt_ff != 6'd0) begin
         char_in = CHAR_ZERO;
      end else if (dleft_ff != '0) begin
         char_in = digit_char(top_digit, upper_ff);
      end else begin
         char_in = CHAR_SPACE;
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= conv_start ? ST_CONV : ST_SCAN;
               end
            end
            ST_CONV: begin
               if (conv_done) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (!(top_digit == 4'd0 && count_ff > 5'd1)) begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit && rem_ff == 7'd1) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Working registers of the number in progress.
   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff      <= negative;
         upper_ff    <= req_chan.upper_case && !req_chan.is_signed;
         zero_pad_ff <= req_chan.zero_pad;
         width_ff    <= 8'(req_chan.field_width) - $signed({7'b0, negative});
         digit_ff    <= {{(DIGIT_BITS - VALUE_BITS){1'b0}}, req_chan.value};
         count_ff    <= COUNT_BITS'(MAX_DIGITS);
      end else if (state_ff == ST_CONV && conv_done) begin
         digit_ff <= conv_bcd;
      end else if (state_ff == ST_SCAN) begin
         if (top_digit == 4'd0 && count_ff > 5'd1) begin
            digit_ff <= {digit_ff[DIGIT_BITS-5:0], 4'h0};
            count_ff <= count_ff - 1'b1;
         end
      end else if (emit && !sign_pend_ff && zcnt_ff == 6'd0 && dleft_ff != '0) begin
         digit_ff <= {digit_ff[DIGIT_BITS-5:0], 4'h0};
      end
   end

   // Emission counters, set up once the digit count is known.
   always_ff @(posedge clock) begin
      if (reset) begin
         sign_pend_ff <= 1'b0;
         zcnt_ff      <= '0;
         dleft_ff     <= '0;
         rem_ff       <= '0;
      end else if (state_ff == ST_SETUP) begin
         sign_pend_ff <= neg_ff;
         if (width_ff > 8'sd0) begin
            rem_ff <= {6'b0, neg_ff} + width_ff[6:0];
         end else begin
            rem_ff <= {6'b0, neg_ff} + {2'b00, count_ff};
         end
         if (zero_pad_ff && pad_diff > 8'sd0) begin
            zcnt_ff <= pad_diff[5:0];
         end else begin
            zcnt_ff <= '0;
         end
         if (width_ff > 8'sd0 && pad_diff < 8'sd0) begin
            dleft_ff <= width_ff[COUNT_BITS-1:0];
         end else begin
            dleft_ff <= count_ff;
         end
      end else if (emit) begin
         rem_ff <= rem_ff - 1'b1;
         if (sign_pend_ff) begin
            sign_pend_ff <= 1'b0;
         end else if (zcnt_ff != 6'd0) begin
            zcnt_ff <= zcnt_ff - 1'b1;
         end else if (dleft_ff != '0) begin
            dleft_ff <= dleft_ff - 1'b1;
         end
      end
   end

   // Output register: holds a word until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff <= char_in;
         last_ff <= (rem_ff == 7'd1);
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = char_ff;
   assign rsp_chan.last      = last_ff;

endmodule
